/* hw/rtl/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants of the polyline Bezier smoother.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam logic [16:0] FracThird    = 17'd21845;
  localparam logic [16:0] FracTwoThird = 17'd43691;
  localparam logic [16:0] FracHalf     = 17'd32768;
  localparam logic [16:0] FracOne      = 17'd65536;

  localparam logic [4:0]  DimReset     = 5'd8;

  // lerp operand selects
  typedef enum logic [3:0] {
    SelP   = 4'd0,
    SelA   = 4'd1,
    SelB   = 4'd2,
    SelN   = 4'd3,
    SelC1  = 4'd4,
    SelC2  = 4'd5,
    SelJ0  = 4'd6,
    SelJ1  = 4'd7,
    SelQ1  = 4'd8,
    SelQ2  = 4'd9,
    SelQ3  = 4'd10,
    SelR1  = 4'd11,
    SelR2  = 4'd12,
    SelT0  = 4'd13
  } sel_e;

  typedef enum logic [1:0] {
    FracT     = 2'd0,
    FracK3    = 2'd1,
    FracK23   = 2'd2,
    FracKHalf = 2'd3
  } frac_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // accept input point
    logic       shift;     // shift window after point
    logic       clear;     // clear window
    logic       seg_init;  // latch a/b/p/n for a segment
    logic       seg_first; // 1: older segment, 0: last segment
    logic       has_p;
    logic       has_n;
    logic       lerp_go;   // perform one lerp
    sel_e       sel_a;
    sel_e       sel_b;
    frac_e      frac;
    sel_e       dst;
    logic       t_go;      // start t divide
    logic       t_step;    // one divide step
    logic [4:0] t_num;
    logic       out_load;  // load output register
    sel_e       out_sel;
    logic       out_cur;   // output the current point
    logic       run_end;
    logic       curve_end;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

/* hw/rtl/polyline_bezier_smoother.sv */
// ----------------------------------------------------------------------------
// polyline_bezier_smoother
// Smooths a streamed 3D polyline with cubic Bezier segments and samples them.
// ----------------------------------------------------------------------------
// Takes one point per item and emits samples_per_segment samples per segment
// once the point after the segment is known; the final point flushes its
// segments and the endpoint. All lerps share one three-lane unit, one lerp
// per cycle, and each t comes from a 21-step bit-serial divider; joints and
// samples wait while the output is stalled, and a non-final point with fewer
// than two earlier points only enters the window.
module polyline_bezier_smoother #(
  parameter int CoordWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [0:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordWidth-1:0] point_x_i,
  input  logic signed [CoordWidth-1:0] point_y_i,
  input  logic signed [CoordWidth-1:0] point_z_i,
  input  logic                         final_point_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CoordWidth-1:0] curve_x_o,
  output logic signed [CoordWidth-1:0] curve_y_o,
  output logic signed [CoordWidth-1:0] curve_z_o,
  output logic                         run_end_o,
  output logic                         curve_end_o
);

  logic [4:0] dim_q;
  pbs_pkg::cmd_t cmd;
  pbs_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= pbs_pkg::DimReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      dim_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, dim_q} : 32'd0;

  pbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .final_point_i,
    .dim_i(dim_q), .sts_i(sts), .cmd_o(cmd)
  );

  pbs_datapath #(.CoordWidth(CoordWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .dim_i(dim_q),
    .point_x_i, .point_y_i, .point_z_i,
    .out_valid_o, .out_ready_i, .curve_x_o, .curve_y_o, .curve_z_o,
    .run_end_o, .curve_end_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_x_o))
    else $error("output dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two items back to back");
  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && curve_end_o |-> run_end_o)
    else $error("curve end without run end");

endmodule

/* hw/rtl/pbs_datapath.sv */
// ----------------------------------------------------------------------------
// pbs_datapath
// Point window, segment register file, shared lerp unit, t divider, output.
// ----------------------------------------------------------------------------
module pbs_datapath #(
  parameter int CoordWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pbs_pkg::cmd_t                cmd_i,
  output pbs_pkg::sts_t                sts_o,
  input  logic [4:0]                   dim_i,
  input  logic signed [CoordWidth-1:0] point_x_i,
  input  logic signed [CoordWidth-1:0] point_y_i,
  input  logic signed [CoordWidth-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CoordWidth-1:0] curve_x_o,
  output logic signed [CoordWidth-1:0] curve_y_o,
  output logic signed [CoordWidth-1:0] curve_z_o,
  output logic                         run_end_o,
  output logic                         curve_end_o
);

  localparam int W = CoordWidth;
  typedef logic signed [W-1:0] crd_t;
  typedef crd_t [2:0] vec_t;

  vec_t win_q [3];
  vec_t win_d [3];
  vec_t cur_q;
  vec_t rf_q [14];
  logic [16:0] t_q;
  logic [16:0] rem_q;
  logic [21:0] tnum_q;

  // window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) win_q[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) win_q[i] <= win_d[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) win_d[i] = win_q[i];
    if (cmd_i.clear) begin
      for (int i = 0; i < 3; i++) win_d[i] = '0;
    end else if (cmd_i.shift) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q[0] <= point_x_i;
      cur_q[1] <= point_y_i;
      cur_q[2] <= point_z_i;
    end
  end

  // lerp unit: one lerp of three lanes per cycle
  vec_t la, lb, lr;
  logic [16:0] lf;

  always_comb begin
    la = rf_q[cmd_i.sel_a];
    lb = rf_q[cmd_i.sel_b];
    unique case (cmd_i.frac)
      pbs_pkg::FracT:     lf = t_q;
      pbs_pkg::FracK3:    lf = pbs_pkg::FracThird;
      pbs_pkg::FracK23:   lf = pbs_pkg::FracTwoThird;
      pbs_pkg::FracKHalf: lf = pbs_pkg::FracHalf;
      default:            lf = t_q;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [W:0]      dl;
    logic signed [W+18:0]   pr;
    logic signed [W+18:0]   rs;
    always_comb begin
      dl = {la[g][W-1], la[g]};
      dl = {lb[g][W-1], lb[g]} - dl;
      pr = (W+19)'(dl) * $signed({2'b00, lf}) + (W+19)'(32768);
      rs = (W+19)'(la[g]) + (pr >>> 16);
      lr[g] = rs[W-1:0];
    end
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_init) begin
      if (cmd_i.seg_first) begin
        rf_q[pbs_pkg::SelP] <= win_q[0];
        rf_q[pbs_pkg::SelA] <= win_q[1];
        rf_q[pbs_pkg::SelB] <= win_q[2];
        rf_q[pbs_pkg::SelN] <= cur_q;
      end else begin
        rf_q[pbs_pkg::SelP] <= win_q[1];
        rf_q[pbs_pkg::SelA] <= win_q[2];
        rf_q[pbs_pkg::SelB] <= cur_q;
        rf_q[pbs_pkg::SelN] <= cur_q;
      end
      rf_q[pbs_pkg::SelJ0] <= cmd_i.seg_first ? win_q[1] : win_q[2];
      rf_q[pbs_pkg::SelJ1] <= cmd_i.seg_first ? win_q[2] : cur_q;
    end else if (cmd_i.lerp_go) begin
      rf_q[cmd_i.dst] <= lr;
    end
  end

  // t = floor(s * 65536 / dim), restoring divide one bit per step
  logic [21:0] rem_sh;
  always_comb rem_sh = {4'd0, rem_q, tnum_q[21]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.t_go) begin
      tnum_q <= {cmd_i.t_num, 17'd0};
      rem_q  <= '0;
      t_q    <= '0;
    end else if (cmd_i.t_step) begin
      tnum_q <= {tnum_q[20:0], 1'b0};
      if (rem_sh >= {17'd0, dim_i}) begin
        rem_q <= 17'(rem_sh - {17'd0, dim_i});
        t_q   <= {t_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_sh[16:0];
        t_q   <= {t_q[15:0], 1'b0};
      end
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_cur) begin
        curve_x_o <= cur_q[0];
        curve_y_o <= cur_q[1];
        curve_z_o <= cur_q[2];
      end else begin
        curve_x_o <= rf_q[cmd_i.out_sel][0];
        curve_y_o <= rf_q[cmd_i.out_sel][1];
        curve_z_o <= rf_q[cmd_i.out_sel][2];
      end
      run_end_o   <= cmd_i.run_end;
      curve_end_o <= cmd_i.curve_end;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

/* hw/rtl/pbs_ctrl.sv */
// ----------------------------------------------------------------------------
// pbs_ctrl
// Sequencer: walks each segment through control points, joints and samples.
// ----------------------------------------------------------------------------
module pbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          final_point_i,
  input  logic [4:0]    dim_i,
  input  pbs_pkg::sts_t sts_i,
  output pbs_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDisp  = 4'd1;
  localparam logic [3:0] StInit  = 4'd2;
  localparam logic [3:0] StPre   = 4'd3;
  localparam logic [3:0] StJoint = 4'd4;
  localparam logic [3:0] StTdiv  = 4'd5;
  localparam logic [3:0] StCast  = 4'd6;
  localparam logic [3:0] StEmit  = 4'd7;
  localparam logic [3:0] StNext  = 4'd8;
  localparam logic [3:0] StEnd   = 4'd9;

  logic [3:0] st_q, st_d;
  logic [1:0] seen_q, seen_d;
  logic       fin_q, fin_d;
  logic       first_q, first_d;   // working on older segment
  logic [3:0] op_q, op_d;
  logic [4:0] s_q, s_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] dim_e;

  always_comb begin
    dim_e = (dim_i == 5'd0) ? 5'd1 : dim_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; seen_q <= '0; fin_q <= 1'b0; first_q <= 1'b0;
      op_q <= '0; s_q <= '0; cnt_q <= '0;
    end else begin
      st_q <= st_d; seen_q <= seen_d; fin_q <= fin_d; first_q <= first_d;
      op_q <= op_d; s_q <= s_d; cnt_q <= cnt_d;
    end
  end

  logic has_p, has_n;
  always_comb begin
    has_p = first_q ? (seen_q == 2'd3) : (seen_q >= 2'd2);
    has_n = first_q;
  end

  always_comb begin
    st_d = st_q; seen_d = seen_q; fin_d = fin_q; first_d = first_q;
    op_d = op_q; s_d = s_q; cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.has_p = has_p;
    cmd_o.has_n = has_n;
    in_ready_o = (st_q == StIdle);
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fin_d = final_point_i;
          st_d  = StDisp;
        end
      end
      StDisp: begin
        if (seen_q >= 2'd2) begin
          first_d = 1'b1; st_d = StInit;
        end else if (fin_q && seen_q == 2'd1) begin
          first_d = 1'b0; st_d = StInit;
        end else if (fin_q) begin
          st_d = StEnd;
        end else begin
          st_d = StNext;
        end
      end
      StInit: begin
        cmd_o.seg_init  = 1'b1;
        cmd_o.seg_first = first_q;
        op_d = '0; st_d = StPre;
      end
      StPre: begin
        // c1, c2, and joint adjustments
        cmd_o.lerp_go = 1'b1;
        op_d = op_q + 4'd1;
        unique case (op_q)
          4'd0: begin
            cmd_o.sel_a = pbs_pkg::SelA; cmd_o.sel_b = pbs_pkg::SelB;
            cmd_o.frac = pbs_pkg::FracK3; cmd_o.dst = pbs_pkg::SelC1;
          end
          4'd1: begin
            cmd_o.sel_a = pbs_pkg::SelA; cmd_o.sel_b = pbs_pkg::SelB;
            cmd_o.frac = pbs_pkg::FracK23; cmd_o.dst = pbs_pkg::SelC2;
          end
          4'd2: begin
            cmd_o.lerp_go = has_p;
            cmd_o.sel_a = pbs_pkg::SelP; cmd_o.sel_b = pbs_pkg::SelA;
            cmd_o.frac = pbs_pkg::FracK23; cmd_o.dst = pbs_pkg::SelJ0;
          end
          4'd3: begin
            cmd_o.lerp_go = has_p;
            cmd_o.sel_a = pbs_pkg::SelJ0; cmd_o.sel_b = pbs_pkg::SelC1;
            cmd_o.frac = pbs_pkg::FracKHalf; cmd_o.dst = pbs_pkg::SelJ0;
          end
          4'd4: begin
            cmd_o.lerp_go = has_n;
            cmd_o.sel_a = pbs_pkg::SelB; cmd_o.sel_b = pbs_pkg::SelN;
            cmd_o.frac = pbs_pkg::FracK3; cmd_o.dst = pbs_pkg::SelJ1;
          end
          default: begin
            cmd_o.lerp_go = has_n;
            cmd_o.sel_a = pbs_pkg::SelC2; cmd_o.sel_b = pbs_pkg::SelJ1;
            cmd_o.frac = pbs_pkg::FracKHalf; cmd_o.dst = pbs_pkg::SelJ1;
            s_d = '0; st_d = StJoint;
          end
        endcase
      end
      StJoint: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = pbs_pkg::SelJ0;
          cmd_o.run_end  = (dim_e == 5'd1) && first_q && !fin_q;
          if (dim_e == 5'd1) begin
            st_d = StNext;
          end else begin
            s_d = 5'd1; st_d = StTdiv;
            cmd_o.t_go = 1'b1; cmd_o.t_num = 5'd1;
            cnt_d = '0;
          end
        end
      end
      StTdiv: begin
        cmd_o.t_step = 1'b1;
        cmd_o.t_num  = s_q;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd21) begin
          cmd_o.t_step = 1'b0;
          op_d = '0; st_d = StCast;
        end
      end
      StCast: begin
        cmd_o.lerp_go = 1'b1;
        cmd_o.frac = pbs_pkg::FracT;
        op_d = op_q + 4'd1;
        unique case (op_q)
          4'd0: begin
            cmd_o.sel_a = pbs_pkg::SelJ0; cmd_o.sel_b = pbs_pkg::SelC1;
            cmd_o.dst = pbs_pkg::SelQ1;
          end
          4'd1: begin
            cmd_o.sel_a = pbs_pkg::SelC1; cmd_o.sel_b = pbs_pkg::SelC2;
            cmd_o.dst = pbs_pkg::SelQ2;
          end
          4'd2: begin
            cmd_o.sel_a = pbs_pkg::SelC2; cmd_o.sel_b = pbs_pkg::SelJ1;
            cmd_o.dst = pbs_pkg::SelQ3;
          end
          4'd3: begin
            cmd_o.sel_a = pbs_pkg::SelQ1; cmd_o.sel_b = pbs_pkg::SelQ2;
            cmd_o.dst = pbs_pkg::SelR1;
          end
          4'd4: begin
            cmd_o.sel_a = pbs_pkg::SelQ2; cmd_o.sel_b = pbs_pkg::SelQ3;
            cmd_o.dst = pbs_pkg::SelR2;
          end
          default: begin
            cmd_o.sel_a = pbs_pkg::SelR1; cmd_o.sel_b = pbs_pkg::SelR2;
            cmd_o.dst = pbs_pkg::SelT0;
            st_d = StEmit;
          end
        endcase
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = pbs_pkg::SelT0;
          cmd_o.run_end  = (s_q == dim_e - 5'd1) && first_q && !fin_q;
          if (s_q == dim_e - 5'd1) begin
            st_d = StNext;
          end else begin
            s_d = s_q + 5'd1;
            cmd_o.t_go = 1'b1; cmd_o.t_num = s_q + 5'd1;
            cnt_d = '0; st_d = StTdiv;
          end
        end
      end
      StNext: begin
        if (fin_q && first_q) begin
          first_d = 1'b0; st_d = StInit;
        end else if (fin_q) begin
          st_d = StEnd;
        end else begin
          cmd_o.shift = 1'b1;
          seen_d = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
          st_d = StIdle;
        end
      end
      StEnd: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_cur   = 1'b1;
          cmd_o.run_end   = 1'b1;
          cmd_o.curve_end = 1'b1;
          cmd_o.clear     = 1'b1;
          seen_d = '0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

endmodule

/* verif/tb_polyline_bezier_smoother.sv */
// ----------------------------------------------------------------------------
// tb_polyline_bezier_smoother
// Self-checking testbench for the streamed polyline Bezier smoother.
// ----------------------------------------------------------------------------
// Streams directed and random-length polylines, partly under random idling on
// both sides, predicts every curve sample in fixed point, and compares each
// output item field by field in order. The samples per segment setting is
// reprogrammed between phases over the APB port, including 0, 1 and 31.
// ----------------------------------------------------------------------------
module tb_polyline_bezier_smoother;

  localparam logic [0:0] AddrDim = 1'b0;
  localparam logic [0:0] AddrSpare = 1'b1;

  typedef struct {
    logic signed [63:0] c[3];
  } pt_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        run_end;
    logic        curve_end;
  } sample_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        fin;
    logic        chk;
    sample_t     want;
  } row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic signed [31:0] point_x_i, point_y_i, point_z_i;
  logic final_point_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] curve_x_o, curve_y_o, curve_z_o;
  logic run_end_o, curve_end_o;

  polyline_bezier_smoother dut (.*);

  sample_t sample_q[$];
  logic    typed_q[$];
  sample_t typed_val_q[$];
  pt_t     win[3];
  int      held;
  logic [4:0] dim_reg;
  int      mismatches;
  bit      out_idle_en;
  bit      drain;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("polyline_bezier_smoother test failed");
    $finish;
  end

  function automatic logic signed [63:0] lerp1(logic signed [63:0] a,
                                               logic signed [63:0] b, int f);
    logic signed [63:0] d;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    d  = b - a;
    lo = d & 64'hFFFF;
    hi = (d - lo) >>> 16;
    return a + hi * f + ((lo * f + 32768) >>> 16);
  endfunction

  function automatic pt_t lerp3(pt_t a, pt_t b, int f);
    pt_t r;
    for (int i = 0; i < 3; i++) r.c[i] = lerp1(a.c[i], b.c[i], f);
    return r;
  endfunction

  task automatic push_sample(pt_t p, logic ce);
    sample_t s;
    s.x = p.c[0][31:0];
    s.y = p.c[1][31:0];
    s.z = p.c[2][31:0];
    s.run_end = 1'b0;
    s.curve_end = ce;
    sample_q.push_back(s);
    typed_q.push_back(1'b0);
    typed_val_q.push_back(s);
  endtask

  task automatic curve_segment(bit has_p, pt_t p, pt_t a, pt_t b, bit has_n, pt_t n);
    pt_t c1, c2, j0, j1, q1, q2, q3, r1, r2;
    int dim, t;
    c1 = lerp3(a, b, pbs_pkg::FracThird);
    c2 = lerp3(a, b, pbs_pkg::FracTwoThird);
    j0 = a;
    j1 = b;
    dim = (dim_reg == 0) ? 1 : dim_reg;
    if (has_p) j0 = lerp3(lerp3(p, a, pbs_pkg::FracTwoThird), c1, pbs_pkg::FracHalf);
    if (has_n) j1 = lerp3(c2, lerp3(b, n, pbs_pkg::FracThird), pbs_pkg::FracHalf);
    push_sample(j0, 1'b0);
    for (int s = 1; s < dim; s++) begin
      t  = (s * 65536) / dim;
      q1 = lerp3(j0, c1, t);
      q2 = lerp3(c1, c2, t);
      q3 = lerp3(c2, j1, t);
      r1 = lerp3(q1, q2, t);
      r2 = lerp3(q2, q3, t);
      push_sample(lerp3(r1, r2, t), 1'b0);
    end
  endtask

  task automatic predict_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic fin, logic chk, sample_t want);
    pt_t cur, nul;
    int n_prior;
    n_prior = sample_q.size();
    cur.c[0] = $signed(x);
    cur.c[1] = $signed(y);
    cur.c[2] = $signed(z);
    nul = cur;
    if (held >= 2) curve_segment(held == 3, win[0], win[1], win[2], 1, cur);
    if (fin) begin
      if (held >= 1) curve_segment(held >= 2, win[1], win[2], cur, 0, nul);
      push_sample(cur, 1'b1);
      for (int i = 0; i < 3; i++) win[i].c = '{0, 0, 0};
      held = 0;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = cur;
      if (held < 3) held++;
    end
    if (sample_q.size() > n_prior) begin
      sample_q[$].run_end = 1'b1;
      typed_val_q[$].run_end = 1'b1;
      if (chk) begin
        typed_q[$] = 1'b1;
        typed_val_q[$] = want;
      end
    end
  endtask

  task automatic apb_write(logic [0:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrDim) dim_reg = data[4:0];
  endtask

  task automatic settle;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin,
                            bit idle, logic chk = 1'b0, sample_t want = '0);
    if (idle && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    final_point_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_point(x, y, z, fin, chk, want);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                            : 32'h8000_0000 + $urandom_range(255);
    endcase
  endfunction

  task automatic random_polyline(bit idle);
    int len, mode;
    len  = $urandom_range(1, 8);
    mode = $urandom_range(0, 2);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == len - 1, idle);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sample_t got, exp_s;
      got = '{curve_x_o, curve_y_o, curve_z_o, run_end_o, curve_end_o};
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        exp_s = sample_q.pop_front();
        if (typed_q.pop_front()) exp_s = typed_val_q[0];
        void'(typed_val_q.pop_front());
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_s, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (out_idle_en && !drain && $urandom_range(3) == 0 && out_ready_i)
      out_ready_i <= 1'b0;
    else if (!out_ready_i && (!out_idle_en || drain || $urandom_range(2) == 0))
      out_ready_i <= 1'b1;
  end

  row_t dir_rows[$];

  initial begin
    row_t r;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    final_point_i = 1'b0;
    out_idle_en = 1'b0;
    drain = 1'b0;
    mismatches = 0;
    held = 0;
    dim_reg = pbs_pkg::DimReset;
    for (int i = 0; i < 3; i++) win[i].c = '{0, 0, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single points: extremes with the endpoint typed in
    r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b1}};
    dir_rows.push_back(r);
    r = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
          '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1}};
    dir_rows.push_back(r);
    // two, three and five point polylines, the two- and five-point ones with extreme x
    r = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0};
    dir_rows.push_back(r);
    r = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0};
    dir_rows.push_back(r);
    for (int i = 0; i < 3; i++) begin
      r = '{32'h0001_0000 * i, 32'hFFFF_0000, 32'h5555_5555, i == 2, 1'b0, '0};
      dir_rows.push_back(r);
    end
    for (int i = 0; i < 5; i++) begin
      r = '{(i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'hAAAA_AAAA ^ i,
            32'h1234_5678 * i, i == 4, 1'b0, '0};
      dir_rows.push_back(r);
    end
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].fin, 0,
                 dir_rows[i].chk, dir_rows[i].want);
    in_valid_i <= 1'b0;
    settle();

    apb_write(AddrSpare, 32'hFFFF_FFFF);
    apb_write(AddrDim, 32'd0);
    for (int i = 0; i < 4; i++)
      send_point($urandom, $urandom, $urandom, i == 3, 0);
    in_valid_i <= 1'b0;
    settle();
    apb_write(AddrDim, 32'd31);
    for (int i = 0; i < 4; i++)
      send_point($urandom, $urandom, $urandom, i == 3, 0);
    in_valid_i <= 1'b0;
    settle();

    out_idle_en = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(AddrDim, (ph == 0) ? 32'd1 : (ph == 5) ? 32'd3 : $urandom_range(1, 6));
      for (int k = 0; k < 10; k++) begin
        random_polyline(ph < 5);
        if (k == 4) begin
          in_valid_i <= 1'b0;
          while (sample_q.size() != 0) @(posedge clk_i);
        end
      end
      if (ph == 4) drain = 1'b1;
      in_valid_i <= 1'b0;
      settle();
    end

    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && sample_q.size() == 0)
      $display("polyline_bezier_smoother test passed");
    else
      $display("polyline_bezier_smoother test failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_datapath.sv
hw/rtl/pbs_ctrl.sv
hw/rtl/polyline_bezier_smoother.sv
verif/tb_polyline_bezier_smoother.sv
